// ===== rtl/rist_pkg.sv =====
// Shared types, sizes and codes for the refcounted inode slot table.
package rist_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int INO_W   = 15;
  localparam int CNT_W   = 8;
  localparam int IDX_W   = 6;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LOADED    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_WRITEBACK = 3'd3;
  localparam logic [STAT_W-1:0] STAT_HELD      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd6;
  localparam logic [STAT_W-1:0] STAT_UNUSED    = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_DONE
  } state_t;

  // Write port of the slot store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [INO_W-1:0]  tag;
    logic [CNT_W-1:0]  count;
  } store_wr_t;

  // Read port of the slot store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } store_rd_t;

endpackage

// ===== rtl/rist_store.sv =====
// Slot store: tag and count memories with per-slot valid bits that are all cleared at once.
module rist_store
  import rist_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  store_rd_t         rd,
  input  store_wr_t         wr,
  input  logic              clr_all,
  output logic [INO_W-1:0]  rd_tag,
  output logic [CNT_W-1:0]  rd_count
);

  logic [INO_W-1:0] tag_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  logic [INO_W-1:0] rd_tag_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_vld_r;

  logic             fwd;

  assign fwd = wr.en && (wr.addr == rd.addr);

  // A slot that was never written since reset or clear reads as count zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tag_mem[wr.addr] <= wr.tag;
      cnt_mem[wr.addr] <= wr.count;
    end
  end

  // Registered read; forward a write to the same slot in the same cycle.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (fwd) begin
        rd_tag_r <= wr.tag;
        rd_cnt_r <= wr.count;
        rd_vld_r <= !clr_all;
      end else begin
        rd_tag_r <= tag_mem[rd.addr];
        rd_cnt_r <= cnt_mem[rd.addr];
        rd_vld_r <= valid_r[rd.addr] && !clr_all;
      end
    end
  end

  assign rd_tag   = rd_tag_r;
  assign rd_count = rd_vld_r ? rd_cnt_r : '0;

endmodule

// ===== rtl/refcounted_inode_slot_table.sv =====
// Top level of the refcounted inode slot table: request sequencer and result register.
//
// The table holds 64 slots, each with an inode tag and an 8-bit reference
// count kept in a memory with a registered read; a slot is held while its count is
// nonzero. A get (request type 0) walks the slots from 0 upward, one memory
// read per cycle, and stops at the first held slot whose tag matches: that
// slot gains a reference (saturating at 255) and the result says hit.
// Without a match the lowest free slot seen in the walk takes the inode with
// a count of 1 (loaded new), and if every slot is held the result says full.
// A put (type 1) reads the named slot once and drops one reference, saying
// writeback when the count reaches zero, still held otherwise, or ignored on
// a free slot. A clear (type 2) frees every slot at once through per-slot
// valid bits; type 3 is answered as ignored. Every request gives exactly one
// result. Requests are taken one at a time: a get walks the slots until a
// hit or the last slot, a put reads its slot once, and a clear reads none;
// each then waits in the done state until the output register is free, and
// the sequencer passes through idle before the next request is taken. The
// memory read port, one slot per cycle, sets the get time. A finished result
// waits in the output register while the next request is accepted; the
// write-back of a request happens when its result enters that register. No
// clearing pass is needed after reset.
module refcounted_inode_slot_table
  import rist_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [INO_W-1:0]  in_inode_number,
  input  logic [IDX_W-1:0]  in_slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [IDX_W-1:0]  out_result_slot,
  output logic [INO_W-1:0]  out_result_inode,
  output logic [CNT_W-1:0]  out_result_count
);

  state_t state_r, state_nxt;

  // Request being worked on
  logic [INO_W-1:0]  req_ino_r,  req_ino_nxt;
  logic [IDX_W-1:0]  req_idx_r,  req_idx_nxt;

  // Walk position and lowest free slot seen so far
  logic [SLOT_W-1:0] scan_r,       scan_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_slot_r,  free_slot_nxt;

  // Decided result and pending write-back
  logic [STAT_W-1:0] pend_status_r, pend_status_nxt;
  logic [IDX_W-1:0]  pend_slot_r,   pend_slot_nxt;
  logic [INO_W-1:0]  pend_inode_r,  pend_inode_nxt;
  logic [CNT_W-1:0]  pend_count_r,  pend_count_nxt;
  logic              pend_wr_r,     pend_wr_nxt;
  logic [SLOT_W-1:0] pend_addr_r,   pend_addr_nxt;

  // Output register
  logic              out_valid_r,  out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_slot_r,   out_slot_nxt;
  logic [INO_W-1:0]  out_inode_r,  out_inode_nxt;
  logic [CNT_W-1:0]  out_count_r,  out_count_nxt;

  store_rd_t        st_rd;
  store_wr_t        st_wr;
  logic             st_clr;
  logic [INO_W-1:0] rd_tag;
  logic [CNT_W-1:0] rd_count;

  logic             hit;
  logic             free_here;
  logic             put_in_range;

  rist_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (st_rd),
    .wr       (st_wr),
    .clr_all  (st_clr),
    .rd_tag   (rd_tag),
    .rd_count (rd_count)
  );

  assign hit          = (rd_count != '0) && (rd_tag == req_ino_r);
  assign free_here    = (rd_count == '0) && !free_found_r;
  assign put_in_range = 32'(in_slot_index) < 32'(SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_ino_r     <= req_ino_nxt;
    req_idx_r     <= req_idx_nxt;
    scan_r        <= scan_nxt;
    free_found_r  <= free_found_nxt;
    free_slot_r   <= free_slot_nxt;
    pend_status_r <= pend_status_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_inode_r  <= pend_inode_nxt;
    pend_count_r  <= pend_count_nxt;
    pend_wr_r     <= pend_wr_nxt;
    pend_addr_r   <= pend_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_inode_r   <= out_inode_nxt;
    out_count_r   <= out_count_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    req_ino_nxt     = req_ino_r;
    req_idx_nxt     = req_idx_r;
    scan_nxt        = scan_r;
    free_found_nxt  = free_found_r;
    free_slot_nxt   = free_slot_r;
    pend_status_nxt = pend_status_r;
    pend_slot_nxt   = pend_slot_r;
    pend_inode_nxt  = pend_inode_r;
    pend_count_nxt  = pend_count_r;
    pend_wr_nxt     = pend_wr_r;
    pend_addr_nxt   = pend_addr_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_inode_nxt   = out_inode_r;
    out_count_nxt   = out_count_r;
    st_rd           = '0;
    st_wr           = '0;
    st_clr          = 1'b0;
    in_ready        = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_ino_nxt = in_inode_number;
          req_idx_nxt = in_slot_index;
          pend_wr_nxt = 1'b0;
          case (in_req_type)
            REQ_GET: begin
              // Start the walk at slot 0
              st_rd.en       = 1'b1;
              st_rd.addr     = '0;
              scan_nxt       = '0;
              free_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            REQ_PUT: begin
              if (put_in_range) begin
                st_rd.en   = 1'b1;
                st_rd.addr = SLOT_W'(in_slot_index);
                state_nxt  = S_PUT;
              end else begin
                pend_status_nxt = STAT_IGNORED;
                pend_slot_nxt   = in_slot_index;
                pend_inode_nxt  = '0;
                pend_count_nxt  = '0;
                state_nxt       = S_DONE;
              end
            end
            REQ_CLEAR: begin
              // Free every slot now; tags stay but are never read while free
              st_clr          = 1'b1;
              pend_status_nxt = STAT_CLEARED;
              pend_slot_nxt   = '0;
              pend_inode_nxt  = '0;
              pend_count_nxt  = '0;
              state_nxt       = S_DONE;
            end
            default: begin
              pend_status_nxt = STAT_IGNORED;
              pend_slot_nxt   = '0;
              pend_inode_nxt  = '0;
              pend_count_nxt  = '0;
              state_nxt       = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read data for slot scan_r is valid this cycle
        if (hit) begin
          pend_status_nxt = STAT_HIT;
          pend_slot_nxt   = IDX_W'(scan_r);
          pend_inode_nxt  = req_ino_r;
          pend_count_nxt  = (rd_count == CNT_MAX) ? CNT_MAX : rd_count + CNT_W'(1);
          pend_wr_nxt     = 1'b1;
          pend_addr_nxt   = scan_r;
          state_nxt       = S_DONE;
        end else begin
          if (free_here) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = scan_r;
          end
          if (scan_r == LAST_SLOT) begin
            if (free_found_r || free_here) begin
              pend_status_nxt = STAT_LOADED;
              pend_slot_nxt   = IDX_W'(free_here ? scan_r : free_slot_r);
              pend_inode_nxt  = req_ino_r;
              pend_count_nxt  = CNT_W'(1);
              pend_wr_nxt     = 1'b1;
              pend_addr_nxt   = free_here ? scan_r : free_slot_r;
            end else begin
              pend_status_nxt = STAT_FULL;
              pend_slot_nxt   = '0;
              pend_inode_nxt  = req_ino_r;
              pend_count_nxt  = '0;
            end
            state_nxt = S_DONE;
          end else begin
            // Advance to the next slot
            st_rd.en   = 1'b1;
            st_rd.addr = scan_r + SLOT_W'(1);
            scan_nxt   = scan_r + SLOT_W'(1);
          end
        end
      end

      S_PUT: begin
        pend_slot_nxt = req_idx_r;
        if (rd_count == '0) begin
          pend_status_nxt = STAT_IGNORED;
          pend_inode_nxt  = '0;
          pend_count_nxt  = '0;
        end else begin
          pend_status_nxt = (rd_count == CNT_W'(1)) ? STAT_WRITEBACK : STAT_HELD;
          pend_inode_nxt  = rd_tag;
          pend_count_nxt  = rd_count - CNT_W'(1);
          pend_wr_nxt     = 1'b1;
          pend_addr_nxt   = SLOT_W'(req_idx_r);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free, then commit the write
        if (!out_valid_r || out_ready) begin
          st_wr.en       = pend_wr_r;
          st_wr.addr     = pend_addr_r;
          st_wr.tag      = pend_inode_r;
          st_wr.count    = pend_count_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_slot_nxt   = pend_slot_r;
          out_inode_nxt  = pend_inode_r;
          out_count_nxt  = pend_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_slot  = out_slot_r;
  assign out_result_inode = out_inode_r;
  assign out_result_count = out_count_r;

endmodule

// ===== rtl/rist_checker.sv =====
// Port-level checker for the refcounted inode slot table, bound to the top level.
module rist_checker
  import rist_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [IDX_W-1:0]  out_result_slot,
  input logic [INO_W-1:0]  out_result_inode,
  input logic [CNT_W-1:0]  out_result_count
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_result_slot) && $stable(out_result_inode) && $stable(out_result_count))
    else $error("result dropped or changed while stalled");

  // No result comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != STAT_UNUSED)
    else $error("undefined status code");

  // A new load starts at one reference; a hit leaves the slot held
  a_count_sense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_LOADED || out_status == STAT_HIT) |->
      out_result_count != '0 &&
      (out_status != STAT_LOADED || out_result_count == CNT_W'(1)))
    else $error("count inconsistent with get status");

  // Writeback means the last reference is gone; still held means some remain
  a_put_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_WRITEBACK || out_status == STAT_HELD) |->
      ((out_status == STAT_WRITEBACK) == (out_result_count == '0)))
    else $error("count inconsistent with put status");

endmodule

bind refcounted_inode_slot_table rist_checker u_rist_checker (.*);
